// ===== hw/rtl/cnwe_pkg.sv =====
// ----------------------------------------------------------------------------
// cnwe_pkg
// Shared types, token codes and microcode for the number word emitter.
// ----------------------------------------------------------------------------
package cnwe_pkg;

  // Word tokens
  localparam logic [3:0] TOK_ZERO = 4'd0;
  localparam logic [3:0] TOK_SHI  = 4'd10;
  localparam logic [3:0] TOK_BAI  = 4'd11;
  localparam logic [3:0] TOK_QIAN = 4'd12;
  localparam logic [3:0] TOK_WAN  = 4'd13;
  localparam logic [3:0] TOK_YI   = 4'd14;
  localparam logic [3:0] TOK_FU   = 4'd15;

  // Magnitude saturation and divide-by-100 reciprocal (exact below 2^32)
  localparam logic [29:0] MAG_LIMIT = 30'd999999999;
  localparam logic [31:0] RECIP100  = 32'h51EB_851F;

  // Microcode address
  localparam int unsigned UA_W = 4;
  typedef logic [UA_W-1:0] uaddr_t;

  localparam uaddr_t UA_IDLE = 4'd0;
  localparam uaddr_t UA_DIV  = 4'd1;
  localparam uaddr_t UA_FIN  = 4'd2;
  localparam uaddr_t UA_SIGN = 4'd3;
  localparam uaddr_t UA_ZW   = 4'd4;
  localparam uaddr_t UA_DIG  = 4'd5;
  localparam uaddr_t UA_PLC  = 4'd6;
  localparam uaddr_t UA_GRP  = 4'd7;
  localparam uaddr_t UA_END  = 4'd8;
  localparam uaddr_t UA_ZERO = 4'd9;

  typedef enum logic [3:0] {
    OP_LOAD,   // take a value, saturate, clear flags
    OP_DIV,    // peel two decimal digits
    OP_FIN,    // store last pair and top digit
    OP_SIGN,   // minus word if negative
    OP_ZW,     // zero word for a closed run of zeros
    OP_DIG,    // digit word
    OP_PLC,    // place unit within group
    OP_GRP,    // group unit, step position down
    OP_END,    // release held token as last
    OP_ZERO    // plain zero reading
  } op_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_NO_IN,
    J_CNT_MORE,
    J_ZERO,
    J_DIG_ZERO,
    J_PLACE_ZERO,
    J_POS_MORE
  } jcond_e;

  typedef struct packed {
    op_e    op;
    jcond_e jc;
    uaddr_t tgt;
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic no_in;
    logic cnt_more;
    logic zero;
    logic dig_zero;
    logic place_zero;
    logic pos_more;
  } cond_t;

  function automatic uword_t urom(input uaddr_t a);
    uword_t w;
    case (a)
      UA_IDLE: w = '{op: OP_LOAD, jc: J_NO_IN,      tgt: UA_IDLE};
      UA_DIV:  w = '{op: OP_DIV,  jc: J_CNT_MORE,   tgt: UA_DIV};
      UA_FIN:  w = '{op: OP_FIN,  jc: J_NEXT,       tgt: UA_IDLE};
      UA_SIGN: w = '{op: OP_SIGN, jc: J_ZERO,       tgt: UA_ZERO};
      UA_ZW:   w = '{op: OP_ZW,   jc: J_DIG_ZERO,   tgt: UA_GRP};
      UA_DIG:  w = '{op: OP_DIG,  jc: J_PLACE_ZERO, tgt: UA_GRP};
      UA_PLC:  w = '{op: OP_PLC,  jc: J_NEXT,       tgt: UA_IDLE};
      UA_GRP:  w = '{op: OP_GRP,  jc: J_POS_MORE,   tgt: UA_ZW};
      UA_END:  w = '{op: OP_END,  jc: J_ALWAYS,     tgt: UA_IDLE};
      UA_ZERO: w = '{op: OP_ZERO, jc: J_ALWAYS,     tgt: UA_END};
      default: w = '{op: OP_LOAD, jc: J_ALWAYS,     tgt: UA_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/cnwe_seq.sv =====
// ----------------------------------------------------------------------------
// cnwe_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module cnwe_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  cnwe_pkg::cond_t  cond_i,
  output cnwe_pkg::uword_t uword_o,
  output cnwe_pkg::uaddr_t upc_o
);
  import cnwe_pkg::*;

  uaddr_t upc_q, upc_d;
  uword_t uw;
  logic   taken;

  assign uw = urom(upc_q);

  always_comb begin
    case (uw.jc)
      J_NEXT:       taken = 1'b0;
      J_ALWAYS:     taken = 1'b1;
      J_NO_IN:      taken = cond_i.no_in;
      J_CNT_MORE:   taken = cond_i.cnt_more;
      J_ZERO:       taken = cond_i.zero;
      J_DIG_ZERO:   taken = cond_i.dig_zero;
      J_PLACE_ZERO: taken = cond_i.place_zero;
      J_POS_MORE:   taken = cond_i.pos_more;
      default:      taken = 1'b0;
    endcase
    upc_d = taken ? uw.tgt : upc_q + uaddr_t'(1);
  end

  // step holds while the output side blocks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_IDLE;
    end else if (fire_i) begin
      upc_q <= upc_d;
    end
  end

  assign uword_o = uw;
  assign upc_o   = upc_q;

endmodule

// ===== hw/rtl/chinese_number_word_emitter.sv =====
// ----------------------------------------------------------------------------
// chinese_number_word_emitter
// Reads a signed integer aloud as a run of Chinese word tokens.
// ----------------------------------------------------------------------------
// One value in, one token per output transaction, last marking the end of the
// reading. Values are taken one at a time: a new value is accepted only once
// the previous reading has been handed to the output holding stage. The
// microcode sequencer first turns the value into decimal digits by repeated
// divide-by-100 steps (one divide-by-100 per step through one 30x32 reciprocal
// multiplier), then emits a minus word if negative and scans the decimal
// positions from the hundred-million place down; zero reads as a plain zero.
// One token is held back in a lookahead register so that last can be set on
// the correct word; a token leaves from an output register that keeps
// working while the sequencer moves on.
module chinese_number_word_emitter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [30:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         token_o,
  output logic               last_o
);
  import cnwe_pkg::*;

  localparam logic [3:0] POS_YI  = 4'd8;  // hundred-million digit
  localparam logic [3:0] POS_WAN = 4'd4;  // bottom of ten-thousand group

  // Sequencer
  uword_t uw;
  uaddr_t upc;
  cond_t  cond;
  logic   fire;

  cnwe_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .cond_i  (cond),
    .uword_o (uw),
    .upc_o   (upc)
  );

  // Datapath state
  logic [29:0] mag_q;
  logic [6:0]  pair_q;
  logic [3:0]  dig_q [9];
  logic [2:0]  cnt_q;
  logic [3:0]  pos_q;
  logic        neg_q, zero_q;
  logic        pending_q, started_q, gnz_q;
  logic        hold_valid_q;
  logic [3:0]  hold_tok_q;
  logic        out_valid_q, out_last_q;
  logic [3:0]  out_tok_q;

  // Input: sign, magnitude, saturation
  logic        in_acc;
  logic [31:0] mag_full;
  logic [29:0] mag_sat;

  assign in_stall_o = (upc != UA_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    if (value_i[30]) begin
      mag_full = 32'h8000_0000 - {1'b0, value_i};
    end else begin
      mag_full = {1'b0, value_i};
    end
    mag_sat = (mag_full > {2'b00, MAG_LIMIT}) ? MAG_LIMIT : mag_full[29:0];
  end

  // Divide by 100 via reciprocal; remainder back out by shift-add
  logic [61:0] prod;
  logic [23:0] quo;
  logic [29:0] q100;
  logic [29:0] rem30;

  assign prod  = 62'(mag_q) * 62'(RECIP100);
  assign quo   = prod[60:37];
  assign q100  = 30'({quo, 6'b0}) + 30'({quo, 5'b0}) + 30'({quo, 2'b0});
  assign rem30 = mag_q - q100;

  // Split stored pair 0..99 into tens and units
  logic [14:0] tens_x;
  logic [3:0]  tens, units;
  logic [1:0]  pidx;

  assign tens_x = 15'(pair_q) * 15'd205;
  assign tens   = tens_x[14:11];
  assign units  = 4'(pair_q - 7'({tens, 3'b0}) - 7'({tens, 1'b0}));
  assign pidx   = 2'(cnt_q - 3'd1);

  // Current digit under scan
  logic [3:0] cur_dig;
  logic       dig_zero;
  logic       grp_pos;

  assign cur_dig  = dig_q[pos_q];
  assign dig_zero = (cur_dig == 4'd0);
  assign grp_pos  = (pos_q == POS_YI) || (pos_q == POS_WAN);

  assign cond = '{
    no_in:      !in_valid_i,
    cnt_more:   (cnt_q != 3'd3),
    zero:       zero_q,
    dig_zero:   dig_zero,
    place_zero: (pos_q[1:0] == 2'd0),
    pos_more:   (pos_q != 4'd0)
  };

  // Token generation per microcode op
  logic       emit_req;
  logic [3:0] emit_tok;
  logic       flush, push, out_free;

  always_comb begin
    emit_req = 1'b0;
    emit_tok = TOK_ZERO;
    case (uw.op)
      OP_SIGN: begin
        emit_req = neg_q;
        emit_tok = TOK_FU;
      end
      OP_ZW: begin
        emit_req = !dig_zero && pending_q;
        emit_tok = TOK_ZERO;
      end
      OP_DIG: begin
        emit_req = 1'b1;
        emit_tok = cur_dig;
      end
      OP_PLC: begin
        emit_req = 1'b1;
        case (pos_q[1:0])
          2'd2:    emit_tok = TOK_BAI;
          2'd3:    emit_tok = TOK_QIAN;
          default: emit_tok = TOK_SHI;
        endcase
      end
      OP_GRP: begin
        emit_req = gnz_q && grp_pos;
        emit_tok = (pos_q == POS_YI) ? TOK_YI : TOK_WAN;
      end
      OP_ZERO: begin
        emit_req = 1'b1;
        emit_tok = TOK_ZERO;
      end
      default: begin
        emit_req = 1'b0;
        emit_tok = TOK_ZERO;
      end
    endcase
  end

  // A new token pushes the held one out; the end step pushes it as last.
  assign flush    = (uw.op == OP_END);
  assign push     = (emit_req && hold_valid_q) || flush;
  assign out_free = !out_valid_q || !out_stall_i;
  assign fire     = !(push && !out_free);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= 3'd0;
      pos_q        <= POS_YI;
      pending_q    <= 1'b0;
      started_q    <= 1'b0;
      gnz_q        <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (push && fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (fire) begin
        if (emit_req) begin
          hold_valid_q <= 1'b1;
        end else if (flush) begin
          hold_valid_q <= 1'b0;
        end

        case (uw.op)
          OP_LOAD: begin
            if (in_acc) begin
              cnt_q     <= 3'd0;
              pos_q     <= POS_YI;
              pending_q <= 1'b0;
              started_q <= 1'b0;
              gnz_q     <= 1'b0;
            end
          end
          OP_DIV: begin
            cnt_q <= cnt_q + 3'd1;
          end
          OP_ZW: begin
            // zeros only count once a nonzero digit has been read
            pending_q <= dig_zero ? started_q : 1'b0;
          end
          OP_DIG: begin
            started_q <= 1'b1;
            gnz_q     <= 1'b1;
          end
          OP_GRP: begin
            if (grp_pos) begin
              gnz_q <= 1'b0;
            end
            if (pos_q != 4'd0) begin
              pos_q <= pos_q - 4'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (push && fire) begin
      out_tok_q  <= hold_tok_q;
      out_last_q <= flush;
    end
    if (fire && emit_req) begin
      hold_tok_q <= emit_tok;
    end
    if (fire) begin
      case (uw.op)
        OP_LOAD: begin
          if (in_acc) begin
            mag_q  <= mag_sat;
            neg_q  <= value_i[30];
            zero_q <= (mag_sat == 30'd0);
          end
        end
        OP_DIV: begin
          mag_q  <= 30'(quo);
          pair_q <= rem30[6:0];
          if (cnt_q != 3'd0) begin
            dig_q[{1'b0, pidx, 1'b0}] <= units;
            dig_q[{1'b0, pidx, 1'b1}] <= tens;
          end
        end
        OP_FIN: begin
          dig_q[{1'b0, pidx, 1'b0}] <= units;
          dig_q[{1'b0, pidx, 1'b1}] <= tens;
          dig_q[POS_YI]             <= mag_q[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign token_o     = out_tok_q;
  assign last_o      = out_last_q;

  // Checks
  a_end_has_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc == UA_END) |-> hold_valid_q)
    else $error("end step reached with no held token");

  a_accept_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !hold_valid_q)
    else $error("value accepted while a token is still held");

  a_fin_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc == UA_FIN) |-> (cnt_q == 3'd4))
    else $error("conversion finished after wrong number of divides");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q <= POS_YI))
    else $error("digit position out of range");

  a_last_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && fire && flush) |=> (out_valid_q && out_last_q && !hold_valid_q))
    else $error("last token not presented after end step");

endmodule
